### sv/msc_pkg.sv
// Package with the shared constants, types and codes of the square-count unit.
`timescale 1ns / 1ps
package msc_pkg;

  localparam int MAX_NUMBER = 4095;
  localparam int NUM_W      = 12;
  localparam int CNT_W      = 3;
  localparam int DEPTH      = MAX_NUMBER + 1;
  localparam int ADDR_W     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int SQ_W       = ADDR_W + 2;
  localparam int J_W        = ADDR_W;

  localparam logic [CNT_W-1:0] COUNT_CEILING = CNT_W'(7);
  localparam logic [CNT_W-1:0] COUNT_ZERO    = CNT_W'(0);
  localparam logic [CNT_W-1:0] COUNT_ONE     = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_READ,
    S_WRITE,
    S_DONE
  } msc_state_t;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_ONE,
    WR_BEST
  } msc_wsel_t;

  typedef struct packed {
    logic      start;
    logic      issue;
    logic      wr_en;
    msc_wsel_t wr_sel;
    logic      next_i;
    logic      load_out;
  } msc_cmd_t;

  typedef struct packed {
    logic sq_le_i;
    logic i_is_target;
    logic target_zero;
    logic target_one;
  } msc_status_t;

endpackage

### sv/min_square_sum_count_unit.sv
// Top level of the unit that finds the least number of perfect squares summing to an integer.
// An input transaction for number n rebuilds a table of best counts from 0 to n in a
// single-port-read memory, one read of the table per cycle; entry i reads the table once
// for each square j*j no greater than i before its best count is written. A new transaction
// is taken only once the previous one has finished its table, but a finished result may
// wait in the output register while the next transaction is accepted.
`timescale 1ns / 1ps
module min_square_sum_count_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [msc_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [msc_pkg::CNT_W-1:0] out_square_count
);

  msc_pkg::msc_cmd_t    cmd;
  msc_pkg::msc_status_t status;

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  msc_datapath u_datapath (
    .clk              (clk),
    .in_number        (in_number),
    .cmd              (cmd),
    .status           (status),
    .out_square_count (out_square_count)
  );

endmodule

### sv/msc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/msc_datapath.sv
// Datapath of the square-count unit: indices, running minimum, table and result register.
`timescale 1ns / 1ps
module msc_datapath (
  input  logic                      clk,
  input  logic [msc_pkg::NUM_W-1:0] in_number,
  input  msc_pkg::msc_cmd_t         cmd,
  output msc_pkg::msc_status_t      status,
  output logic [msc_pkg::CNT_W-1:0] out_square_count
);

  logic [msc_pkg::ADDR_W-1:0] target_r, target_nxt;
  logic [msc_pkg::ADDR_W-1:0] i_r, i_nxt;
  logic [msc_pkg::J_W-1:0]    j_r, j_nxt;
  logic [msc_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [msc_pkg::CNT_W-1:0]  best_r, best_nxt;
  logic [msc_pkg::CNT_W-1:0]  result_r, result_nxt;
  logic                       pending_r, pending_nxt;

  logic [msc_pkg::ADDR_W-1:0] wr_addr;
  logic [msc_pkg::CNT_W-1:0]  wr_data;
  logic [msc_pkg::ADDR_W-1:0] rd_addr;
  logic [msc_pkg::CNT_W-1:0]  rd_data;
  logic [msc_pkg::CNT_W:0]    cand;

  always_comb begin
    case (cmd.wr_sel)
      msc_pkg::WR_ZERO: begin
        wr_addr = msc_pkg::ADDR_W'(0);
        wr_data = msc_pkg::COUNT_ZERO;
      end
      msc_pkg::WR_ONE: begin
        wr_addr = msc_pkg::ADDR_W'(1);
        wr_data = msc_pkg::COUNT_ONE;
      end
      default: begin
        wr_addr = i_r;
        wr_data = best_r;
      end
    endcase
  end

  assign rd_addr = msc_pkg::ADDR_W'({2'b00, i_r} - sq_r);
  assign cand    = {1'b0, rd_data} + (msc_pkg::CNT_W + 1)'(1);

  msc_ram #(
    .WIDTH (msc_pkg::CNT_W),
    .DEPTH (msc_pkg::DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    target_nxt  = target_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    sq_nxt      = sq_r;
    best_nxt    = best_r;
    result_nxt  = result_r;
    pending_nxt = cmd.issue;

    if (pending_r && (cand < {1'b0, best_r})) begin
      best_nxt = cand[msc_pkg::CNT_W-1:0];
    end

    if (cmd.start) begin
      if (32'(in_number) > msc_pkg::MAX_NUMBER) begin
        target_nxt = msc_pkg::ADDR_W'(msc_pkg::MAX_NUMBER);
      end else begin
        target_nxt = msc_pkg::ADDR_W'(in_number);
      end
    end

    if (cmd.start || cmd.next_i) begin
      i_nxt    = cmd.start ? msc_pkg::ADDR_W'(2) : i_r + msc_pkg::ADDR_W'(1);
      j_nxt    = msc_pkg::J_W'(1);
      sq_nxt   = msc_pkg::SQ_W'(1);
      best_nxt = msc_pkg::COUNT_CEILING;
    end

    if (cmd.issue) begin
      j_nxt  = j_r + msc_pkg::J_W'(1);
      sq_nxt = sq_r + msc_pkg::SQ_W'({j_r, 1'b1});
    end

    if (cmd.wr_en && (cmd.wr_sel != msc_pkg::WR_BEST)) begin
      best_nxt = (status.target_zero || status.target_one) ? wr_data
                                                           : msc_pkg::COUNT_CEILING;
    end

    if (cmd.load_out) begin
      result_nxt = best_r;
    end
  end

  always_ff @(posedge clk) begin
    target_r  <= target_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    sq_r      <= sq_nxt;
    best_r    <= best_nxt;
    result_r  <= result_nxt;
    pending_r <= pending_nxt;
  end

  assign status.sq_le_i     = (sq_r <= {2'b00, i_r});
  assign status.i_is_target = (i_r == target_r);
  assign status.target_zero = (target_r == msc_pkg::ADDR_W'(0));
  assign status.target_one  = (target_r == msc_pkg::ADDR_W'(1));
  assign out_square_count   = result_r;

endmodule

### sv/msc_ctrl.sv
// Controller state machine of the square-count unit.
`timescale 1ns / 1ps
module msc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  msc_pkg::msc_status_t status,
  output msc_pkg::msc_cmd_t    cmd
);

  msc_pkg::msc_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.start    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.wr_en    = 1'b0;
    cmd.wr_sel   = msc_pkg::WR_BEST;
    cmd.next_i   = 1'b0;
    cmd.load_out = 1'b0;

    unique case (state_r)
      msc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = msc_pkg::S_INIT0;
        end
      end
      msc_pkg::S_INIT0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = msc_pkg::WR_ZERO;
        state_nxt  = status.target_zero ? msc_pkg::S_DONE : msc_pkg::S_INIT1;
      end
      msc_pkg::S_INIT1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = msc_pkg::WR_ONE;
        state_nxt  = status.target_one ? msc_pkg::S_DONE : msc_pkg::S_READ;
      end
      msc_pkg::S_READ: begin
        if (status.sq_le_i) begin
          cmd.issue = 1'b1;
        end else begin
          state_nxt = msc_pkg::S_WRITE;
        end
      end
      msc_pkg::S_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = msc_pkg::WR_BEST;
        if (status.i_is_target) begin
          state_nxt = msc_pkg::S_DONE;
        end else begin
          cmd.next_i = 1'b1;
          state_nxt  = msc_pkg::S_READ;
        end
      end
      msc_pkg::S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = msc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = msc_pkg::S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != msc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/msc_checker.sv
// Port-level assertions for the square-count unit, with the bind that attaches them.
`timescale 1ns / 1ps
module msc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [msc_pkg::CNT_W-1:0] out_square_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result transaction was withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_square_count))
    else $error("stalled result payload changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_square_count <= msc_pkg::CNT_W'(4))
    else $error("square count above four");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the table was rebuilt");

endmodule

bind min_square_sum_count_unit msc_checker u_msc_checker (.*);

### dv/tb_min_square_sum_count_unit.sv
// Self-checking testbench of the least perfect-square count unit.
`timescale 1ns / 1ps
module tb_min_square_sum_count_unit;

  localparam int unsigned IDLE_LIMIT   = 600000;
  localparam int unsigned LONG_HOLD    = 3000;
  localparam int unsigned HOLD_AFTER   = 30;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    logic [msc_pkg::NUM_W-1:0] number;
    logic [msc_pkg::CNT_W-1:0] count;
  } square_case_t;

  class square_count_board;
    square_case_t              expected_counts[$];
    logic [msc_pkg::CNT_W-1:0] best_table[msc_pkg::DEPTH];
    int unsigned               mismatch_count;
    int unsigned               results_seen;

    function logic [msc_pkg::CNT_W-1:0] least_square_count(
        logic [msc_pkg::NUM_W-1:0] number);
      int unsigned target;
      int unsigned i;
      int unsigned j;
      int unsigned best;
      int unsigned cand;
      target = 32'(number);
      if (target > msc_pkg::MAX_NUMBER) begin
        target = msc_pkg::MAX_NUMBER;
      end
      best_table[0] = msc_pkg::COUNT_ZERO;
      if (target == 0) begin
        return msc_pkg::COUNT_ZERO;
      end
      best_table[1] = msc_pkg::COUNT_ONE;
      for (i = 2; i <= target; i++) begin
        best = 32'(msc_pkg::COUNT_CEILING);
        for (j = 1; j * j <= i; j++) begin
          cand = 1 + 32'(best_table[i - j * j]);
          if (cand < best) begin
            best = cand;
          end
        end
        best_table[i] = best[msc_pkg::CNT_W-1:0];
      end
      return best_table[target];
    endfunction

    function void note_number(logic [msc_pkg::NUM_W-1:0] number);
      square_case_t entry;
      entry.number = number;
      entry.count  = least_square_count(number);
      expected_counts.push_back(entry);
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: error: %s", $time, what);
      mismatch_count++;
    endtask

    task check_count(logic [msc_pkg::CNT_W-1:0] got);
      square_case_t entry;
      results_seen++;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("square count %0d with no transaction pending", got));
        return;
      end
      entry = expected_counts.pop_front();
      if (got !== entry.count) begin
        report_mismatch($sformatf("number %0d gave square count %0d, want %0d",
                                  entry.number, got, entry.count));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [msc_pkg::NUM_W-1:0] in_number;
  logic                      out_valid;
  logic                      out_stall;
  logic [msc_pkg::CNT_W-1:0] out_square_count;

  square_count_board board = new();
  int unsigned       send_calm = 0;
  int unsigned       recv_calm = 0;
  int unsigned       quiet_cycles = 0;

  min_square_sum_count_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_square_count (out_square_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_number(input logic [msc_pkg::NUM_W-1:0] number,
                              input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (in_stall);
    board.note_number(number);
  endtask

  task automatic wait_all_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_count(out_square_count);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("min_square_sum_count_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver holds off once for a long stretch so that the unit fills up and stalls its input.
  initial begin : receiver
    int unsigned stall_left;
    bit          long_hold_done;
    out_stall      = 1'b0;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && board.results_seen >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(recv_calm);
      end
    end
  end

  initial begin : stimulus
    logic [msc_pkg::NUM_W-1:0] corners[25];
    int unsigned               k;
    int unsigned               roll;
    logic [msc_pkg::NUM_W-1:0] number;
    corners = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 11, 12, 15, 16, 23, 27, 28, 31, 32, 48, 63, 64, 112, 127, 255,
      4095
    };
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_number = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < $size(corners); k++) begin
      offer_number(corners[k], pick_gap(send_calm));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait_all_results();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        number = msc_pkg::NUM_W'($urandom_range(0, 31));
      end else if (roll < 90) begin
        number = msc_pkg::NUM_W'($urandom_range(32, 255));
      end else begin
        number = msc_pkg::NUM_W'($urandom_range(256, 1023));
      end
      offer_number(number, pick_gap(send_calm));
      if (k == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_all_results();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("min_square_sum_count_unit: match");
    end else begin
      $display("min_square_sum_count_unit: mismatch");
    end
    $finish;
  end

endmodule
